[hdl/bsl_pkg.sv]
// shared types and constants for the sorted leaderboard
package bsl_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 64;
    localparam int KEY_W    = 64;

    localparam logic [1:0] FUNC_UPDATE = 2'd0;
    localparam logic [1:0] FUNC_RANK   = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_UNCHANGED = 3'd2;
    localparam logic [2:0] ST_REJECTED  = 3'd3;
    localparam logic [2:0] ST_FOUND     = 3'd4;
    localparam logic [2:0] ST_NOTFOUND  = 3'd5;

    // per-cell shift command applied in the execute state
    typedef enum logic [1:0] {
        SH_HOLD  = 2'd0,
        SH_LEFT  = 2'd1,
        SH_RIGHT = 2'd2,
        SH_LOAD  = 2'd3
    } shift_t;

    typedef struct packed {
        logic             valid;
        logic             id_hit;
        logic             key_ge;
        logic             key_gt;
        logic             key_eq;
    } cell_flags_t;

endpackage

[hdl/bounded_sorted_leaderboard.sv]
// top level of the bounded sorted leaderboard
// usage:
//   s_ channel carries one command item (update, rank query, read entry, clear).
//   m_ channel returns exactly one result item per command, in order.
//   list_limit is written by the user via cfg_we / cfg_wdata only while idle; the block does not enforce it.
// timing:
//   an item is latched at the accepting edge; the next cycle registers the
//   compare flags of all cells in the chain; the cycle after that applies the
//   shift of the chain and loads the output register, which raises m_valid.
//   a new item is taken only after the block is back in idle, so one item at
//   a time passes through the compare/shift pass of the cell chain.
//   a moved entry is handled as one combined shift: the cells between its old
//   and new place slide one step toward the old place, the entry is loaded at
//   the new place.
// reset: list empty, list_limit 0 (full capacity), no result pending.
// stall: a result waits in the output register until m_ready; the next item is
//   accepted once the block is idle and the register is free or being emptied.
module bounded_sorted_leaderboard (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [6:0]                    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_func,
    input  logic [bsl_pkg::ID_W-1:0]      s_player_id,
    input  logic [bsl_pkg::KEY_W-1:0]     s_sort_key,
    input  logic [5:0]                    s_position,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_outcome,
    output logic [6:0]                    m_rank,
    output logic [bsl_pkg::ID_W-1:0]      m_entry_id,
    output logic [bsl_pkg::KEY_W-1:0]     m_entry_key,
    output logic [6:0]                    m_entry_count
);

    localparam int N = bsl_pkg::CAPACITY;
    localparam int CW = bsl_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EXEC = 3'b100
    } fsm_t;

    fsm_t state_reg, state_next;

    logic [6:0]                limit_reg;
    logic [CW-1:0]             count_reg, count_next;
    logic [1:0]                func_reg;
    logic [bsl_pkg::ID_W-1:0]  pid_reg;
    logic [bsl_pkg::KEY_W-1:0] key_reg;
    logic [5:0]                pos_reg;

    logic                      cvalid [N];
    logic [bsl_pkg::ID_W-1:0]  cid    [N];
    logic [bsl_pkg::KEY_W-1:0] ckey   [N];
    bsl_pkg::cell_flags_t      cflag  [N];
    bsl_pkg::shift_t           cshift [N];
    logic [N-1:0]              hit_reg, ge_reg, gt_reg, eq_reg;
    logic                      clear_c;

    logic                      out_valid_reg;
    logic [2:0]                out_status_reg;
    logic [6:0]                out_rank_reg;
    logic [bsl_pkg::ID_W-1:0]  out_id_reg;
    logic [bsl_pkg::KEY_W-1:0] out_key_reg;
    logic [6:0]                out_count_reg;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic                      lv, rv;
            logic [bsl_pkg::ID_W-1:0]  li, ri;
            logic [bsl_pkg::KEY_W-1:0] lk, rk;
            if (g == 0) begin : g_first
                assign lv = 1'b0;
                assign li = '0;
                assign lk = '0;
            end else begin : g_mid
                assign lv = cvalid[g-1];
                assign li = cid[g-1];
                assign lk = ckey[g-1];
            end
            if (g == N - 1) begin : g_last
                assign rv = 1'b0;
                assign ri = '0;
                assign rk = '0;
            end else begin : g_nmid
                assign rv = cvalid[g+1];
                assign ri = cid[g+1];
                assign rk = ckey[g+1];
            end
            bsl_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .clear       (clear_c),
                .cmp_id      (pid_reg),
                .cmp_key     (key_reg),
                .shift       (cshift[g]),
                .load_valid  (1'b1),
                .load_id     (pid_reg),
                .load_key    (key_reg),
                .left_valid  (lv),
                .left_id     (li),
                .left_key    (lk),
                .right_valid (rv),
                .right_id    (ri),
                .right_key   (rk),
                .valid       (cvalid[g]),
                .id          (cid[g]),
                .key         (ckey[g]),
                .flags       (cflag[g])
            );
        end
    endgenerate

    // compare flags registered in the compare cycle
    always_ff @(posedge aclk) begin
        if (state_reg == S_CMP) begin
            for (int i = 0; i < N; i++) begin
                hit_reg[i] <= cflag[i].id_hit;
                ge_reg[i]  <= cflag[i].key_ge;
                gt_reg[i]  <= cflag[i].key_gt;
                eq_reg[i]  <= cflag[i].key_eq;
            end
        end
    end

    // decode in the execute cycle
    logic              found;
    logic [CW-1:0]     at;
    logic [CW-1:0]     ins_new;
    logic [CW-1:0]     ins_mov;
    logic [CW-1:0]     lim;
    logic              same_key, prev_le, next_gt;
    logic [2:0]        st;
    logic [6:0]        rk_o;
    logic [bsl_pkg::ID_W-1:0]  eid;
    logic [bsl_pkg::KEY_W-1:0] ekey;
    logic [CW-1:0]     lo, hi, dst;
    logic              do_move, do_ins, shl, shr;

    always_comb begin
        found = |hit_reg;
        at    = count_reg;
        for (int i = N - 1; i >= 0; i--) begin
            if (hit_reg[i]) begin
                at = CW'(i);
            end
        end
        // key >= new key holds on a prefix of the descending list
        ins_new = CW'(N);
        for (int i = N - 1; i >= 0; i--) begin
            if (!ge_reg[i]) begin
                ins_new = CW'(i);
            end
        end
        // same count, skipping the listed player
        ins_mov  = (|(hit_reg & ge_reg)) ? ins_new - CW'(1) : ins_new;
        same_key = |(hit_reg & eq_reg);
        prev_le  = |(hit_reg[N-1:1] & ~gt_reg[N-2:0]);
        next_gt  = |(hit_reg[N-2:0] & gt_reg[N-1:1]);
    end

    always_comb begin
        lim = (limit_reg == 7'd0 || 32'(limit_reg) > N) ? CW'(N) : CW'(limit_reg);
        st         = bsl_pkg::ST_NOTFOUND;
        rk_o       = '0;
        eid        = '0;
        ekey       = '0;
        count_next = count_reg;
        clear_c    = 1'b0;
        do_move    = 1'b0;
        do_ins     = 1'b0;
        lo         = '0;
        hi         = '0;
        dst        = '0;
        shl        = 1'b0;
        shr        = 1'b0;
        unique case (func_reg)
            bsl_pkg::FUNC_UPDATE: begin
                if (found) begin
                    if (same_key) begin
                        st   = bsl_pkg::ST_UNCHANGED;
                        rk_o = 7'(at + CW'(1));
                    end else begin
                        st = bsl_pkg::ST_UPDATED;
                        if (prev_le || next_gt) begin
                            do_move = 1'b1;
                            dst     = ins_mov;
                            if (ins_mov < at) begin
                                // move up: cells dst..at-1 slide right
                                shr = 1'b1;
                                lo  = ins_mov;
                                hi  = at;
                            end else begin
                                // move down: cells at..dst-1 take right neighbor
                                shl = 1'b1;
                                lo  = at;
                                hi  = ins_mov;
                            end
                        end else begin
                            do_move = 1'b1;
                            dst     = at;
                        end
                        rk_o = 7'(dst + CW'(1));
                    end
                end else begin
                    if (count_reg >= lim && count_reg != '0 && ins_new == count_reg) begin
                        st = bsl_pkg::ST_REJECTED;
                    end else begin
                        st     = bsl_pkg::ST_INSERTED;
                        do_ins = 1'b1;
                        dst    = ins_new;
                        shr    = 1'b1;
                        lo     = ins_new;
                        if (count_reg >= lim && count_reg != '0) begin
                            // evict last: shift only up to count-1
                            hi = count_reg - CW'(1);
                            // inserting past the evicted slot lands on it
                            if (ins_new > count_reg - CW'(1)) begin
                                dst = count_reg - CW'(1);
                            end
                        end else begin
                            hi         = count_reg;
                            count_next = count_reg + CW'(1);
                        end
                        rk_o = 7'(dst + CW'(1));
                    end
                end
            end
            bsl_pkg::FUNC_RANK: begin
                if (found && pid_reg != '0) begin
                    st   = bsl_pkg::ST_FOUND;
                    rk_o = 7'(at + CW'(1));
                end
            end
            bsl_pkg::FUNC_READ: begin
                if (CW'(pos_reg) < count_reg) begin
                    st   = bsl_pkg::ST_FOUND;
                    rk_o = 7'(CW'(pos_reg) + CW'(1));
                    eid  = cid[pos_reg[bsl_pkg::IDX_W-1:0]];
                    ekey = ckey[pos_reg[bsl_pkg::IDX_W-1:0]];
                end
            end
            bsl_pkg::FUNC_CLEAR: begin
                st         = bsl_pkg::ST_UPDATED;
                count_next = '0;
                clear_c    = (state_reg == S_EXEC);
            end
            default: ;
        endcase
        if (state_reg != S_EXEC) begin
            clear_c = 1'b0;
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            cshift[i] = bsl_pkg::SH_HOLD;
            if (state_reg == S_EXEC && (do_move || do_ins)) begin
                if (CW'(i) == dst) begin
                    cshift[i] = bsl_pkg::SH_LOAD;
                end else if (shr && CW'(i) > lo && CW'(i) <= hi) begin
                    cshift[i] = bsl_pkg::SH_LEFT;
                end else if (shl && CW'(i) >= lo && CW'(i) < hi) begin
                    cshift[i] = bsl_pkg::SH_RIGHT;
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid && s_ready) state_next = S_CMP;
            S_CMP:  state_next = S_EXEC;
            S_EXEC: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE) && (!out_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            limit_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (state_reg == S_EXEC) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            pid_reg  <= s_player_id;
            key_reg  <= s_sort_key;
            pos_reg  <= s_position;
        end
        if (state_reg == S_EXEC) begin
            out_status_reg <= st;
            out_rank_reg   <= rk_o;
            out_id_reg     <= eid;
            out_key_reg    <= ekey;
            out_count_reg  <= 7'(count_next);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_outcome     = out_status_reg;
    assign m_rank        = out_rank_reg;
    assign m_entry_id    = out_id_reg;
    assign m_entry_key   = out_key_reg;
    assign m_entry_count = out_count_reg;

endmodule

[hdl/bsl_cell.sv]
// one leaderboard slot: holds an entry, compares it and shifts with its neighbors
module bsl_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  logic [bsl_pkg::ID_W-1:0]      cmp_id,
    input  logic [bsl_pkg::KEY_W-1:0]     cmp_key,
    input  bsl_pkg::shift_t               shift,
    input  logic                          load_valid,
    input  logic [bsl_pkg::ID_W-1:0]      load_id,
    input  logic [bsl_pkg::KEY_W-1:0]     load_key,
    input  logic                          left_valid,
    input  logic [bsl_pkg::ID_W-1:0]      left_id,
    input  logic [bsl_pkg::KEY_W-1:0]     left_key,
    input  logic                          right_valid,
    input  logic [bsl_pkg::ID_W-1:0]      right_id,
    input  logic [bsl_pkg::KEY_W-1:0]     right_key,
    output logic                          valid,
    output logic [bsl_pkg::ID_W-1:0]      id,
    output logic [bsl_pkg::KEY_W-1:0]     key,
    output bsl_pkg::cell_flags_t          flags
);

    logic                      valid_reg, valid_next;
    logic [bsl_pkg::ID_W-1:0]  id_reg, id_next;
    logic [bsl_pkg::KEY_W-1:0] key_reg, key_next;

    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        key_next   = key_reg;
        case (shift)
            bsl_pkg::SH_LEFT: begin
                valid_next = left_valid;
                id_next    = left_id;
                key_next   = left_key;
            end
            bsl_pkg::SH_RIGHT: begin
                valid_next = right_valid;
                id_next    = right_id;
                key_next   = right_key;
            end
            bsl_pkg::SH_LOAD: begin
                valid_next = load_valid;
                id_next    = load_id;
                key_next   = load_key;
            end
            default: ;
        endcase
        if (clear) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        id_reg  <= id_next;
        key_reg <= key_next;
    end

    assign valid        = valid_reg;
    assign id           = id_reg;
    assign key          = key_reg;
    assign flags.valid  = valid_reg;
    assign flags.id_hit = valid_reg && (id_reg == cmp_id);
    assign flags.key_ge = valid_reg && (key_reg >= cmp_key);
    assign flags.key_gt = valid_reg && (key_reg > cmp_key);
    assign flags.key_eq = valid_reg && (key_reg == cmp_key);

endmodule

[hdl/bsl_checker.sv]
// port-level checks for the leaderboard
module bsl_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_outcome,
    input logic [6:0] m_rank,
    input logic [6:0] m_entry_count
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_outcome) && $stable(m_rank))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_outcome <= bsl_pkg::ST_NOTFOUND)
        else $error("bad status");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_count <= 7'(bsl_pkg::CAPACITY))
        else $error("count beyond capacity");

    a_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_outcome == bsl_pkg::ST_FOUND || m_outcome == bsl_pkg::ST_INSERTED)
        |-> m_rank != 7'd0 && m_rank <= m_entry_count)
        else $error("rank out of list");

    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item taken while busy");

endmodule

bind bounded_sorted_leaderboard bsl_checker u_bsl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_outcome     (m_outcome),
    .m_rank        (m_rank),
    .m_entry_count (m_entry_count)
);

[dv/tb_bounded_sorted_leaderboard.sv]
// self-checking testbench for the bounded sorted leaderboard
`timescale 1ns / 1ps

module tb_bounded_sorted_leaderboard;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  rank;
        logic [63:0] entry_id;
        logic [63:0] entry_key;
        logic [6:0]  entry_count;
    } board_result_t;

    class board_scoreboard;
        logic [63:0]   ids[bsl_pkg::CAPACITY];
        logic [63:0]   keys[bsl_pkg::CAPACITY];
        int            count;
        int            limit;
        board_result_t pending[$];
        int            errors;
        int            checked;

        function int find_player(logic [63:0] pid);
            int i;
            for (i = 0; i < count; i++) begin
                if (ids[i] == pid) return i;
            end
            return count;
        endfunction

        function void remove_at(int pos);
            int i;
            for (i = pos; i + 1 < count; i++) begin
                ids[i] = ids[i + 1];
                keys[i] = keys[i + 1];
            end
            count--;
        endfunction

        function int insert_sorted(logic [63:0] pid, logic [63:0] key);
            int pos;
            int i;
            pos = 0;
            while (pos < count && keys[pos] >= key) pos++;
            for (i = count; i > pos; i--) begin
                ids[i] = ids[i - 1];
                keys[i] = keys[i - 1];
            end
            ids[pos] = pid;
            keys[pos] = key;
            count++;
            return pos;
        endfunction

        function void note_item(logic [1:0] func, logic [63:0] pid, logic [63:0] key,
                                logic [5:0] position);
            board_result_t r;
            int at;
            int lim;
            bit mv;
            bit ok;
            r = '0;
            r.status = bsl_pkg::ST_NOTFOUND;
            case (func)
                bsl_pkg::FUNC_UPDATE: begin
                    at = find_player(pid);
                    if (at < count) begin
                        if (keys[at] == key) begin
                            r.status = bsl_pkg::ST_UNCHANGED;
                            r.rank = 7'(at + 1);
                        end else begin
                            keys[at] = key;
                            mv = (at > 0 && key >= keys[at - 1]) ||
                                 (at + 1 < count && key < keys[at + 1]);
                            if (mv) begin
                                remove_at(at);
                                at = insert_sorted(pid, key);
                            end
                            r.status = bsl_pkg::ST_UPDATED;
                            r.rank = 7'(at + 1);
                        end
                    end else begin
                        lim = (limit == 0 || limit > bsl_pkg::CAPACITY) ?
                              bsl_pkg::CAPACITY : limit;
                        ok = 1;
                        if (count >= lim && count > 0) begin
                            if (key <= keys[count - 1]) ok = 0;
                            else remove_at(count - 1);
                        end
                        if (ok) begin
                            at = insert_sorted(pid, key);
                            r.status = bsl_pkg::ST_INSERTED;
                            r.rank = 7'(at + 1);
                        end else begin
                            r.status = bsl_pkg::ST_REJECTED;
                        end
                    end
                end
                bsl_pkg::FUNC_RANK: begin
                    at = (pid == 0) ? count : find_player(pid);
                    if (at < count) begin
                        r.status = bsl_pkg::ST_FOUND;
                        r.rank = 7'(at + 1);
                    end
                end
                bsl_pkg::FUNC_READ: begin
                    if (position < count) begin
                        r.status = bsl_pkg::ST_FOUND;
                        r.rank = 7'(position + 1);
                        r.entry_id = ids[position];
                        r.entry_key = keys[position];
                    end
                end
                default: begin
                    count = 0;
                    r.status = bsl_pkg::ST_UPDATED;
                end
            endcase
            r.entry_count = 7'(count);
            pending = {pending, r};
        endfunction

        function void check_result(board_result_t got);
            board_result_t want;
            if (pending.size() == 0) begin
                $error("result with nothing pending");
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.rank !== want.rank) begin
                $error("rank expected %0d actual %0d", want.rank, got.rank);
                errors++;
            end
            if (got.entry_id !== want.entry_id) begin
                $error("entry_id expected %h actual %h", want.entry_id, got.entry_id);
                errors++;
            end
            if (got.entry_key !== want.entry_key) begin
                $error("entry_key expected %h actual %h", want.entry_key, got.entry_key);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count expected %0d actual %0d", want.entry_count,
                       got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_func;
    logic [63:0] s_player_id;
    logic [63:0] s_sort_key;
    logic [5:0]  s_position;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_outcome;
    logic [6:0]  m_rank;
    logic [63:0] m_entry_id;
    logic [63:0] m_entry_key;
    logic [6:0]  m_entry_count;

    board_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles;
    int item_total;
    int clear_total;

    bounded_sorted_leaderboard i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_player_id   (s_player_id),
        .s_sort_key    (s_sort_key),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_outcome     (m_outcome),
        .m_rank        (m_rank),
        .m_entry_id    (m_entry_id),
        .m_entry_key   (m_entry_key),
        .m_entry_count (m_entry_count)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // receiver: random stalls plus an optional long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result({m_outcome, m_rank, m_entry_id, m_entry_key, m_entry_count});
        end
    end

    task automatic send_item(logic [1:0] func, logic [63:0] pid, logic [63:0] key,
                             logic [5:0] position);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_player_id <= pid;
        s_sort_key <= key;
        s_position <= position;
        do @(posedge aclk); while (!s_ready);
        board.note_item(func, pid, key, position);
        item_total++;
        if (func == bsl_pkg::FUNC_CLEAR) clear_total++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (5) @(negedge aclk);
    endtask

    task automatic write_limit(logic [6:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        board.limit = value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // small id/key pools so that hits, ties and moves are common
    function automatic logic [63:0] pick_id();
        if ($urandom_range(9) == 0) return rand64();
        return 64'($urandom_range(20));
    endfunction

    function automatic logic [63:0] pick_key();
        case ($urandom_range(9))
            0: return rand64();
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return 64'd0;
            default: return 64'($urandom_range(30));
        endcase
    endfunction

    task automatic random_phase(int n);
        int i;
        logic [1:0] f;
        for (i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0: f = bsl_pkg::FUNC_CLEAR;
                1, 2, 3: f = bsl_pkg::FUNC_RANK;
                4, 5, 6: f = bsl_pkg::FUNC_READ;
                default: f = bsl_pkg::FUNC_UPDATE;
            endcase
            send_item(f, pick_id(), pick_key(), 6'($urandom_range(63)));
        end
    endtask

    task automatic fill_board(int n);
        int i;
        for (i = 0; i < n; i++) begin
            send_item(bsl_pkg::FUNC_UPDATE, 64'(1000 + i), 64'($urandom_range(500)), 6'd0);
        end
    endtask

    initial begin
        #2_000_000;
        $display("tb_bounded_sorted_leaderboard: FAIL");
        $finish;
    end

    initial begin
        board = new();
        board.count = 0;
        board.limit = 0;
        board.errors = 0;
        board.checked = 0;
        item_total = 0;
        clear_total = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_func = bsl_pkg::FUNC_UPDATE;
        s_player_id = '0;
        s_sort_key = '0;
        s_position = '0;
        m_ready = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty reads, extremes, ties, moves, id zero, clear
        send_item(bsl_pkg::FUNC_READ, 0, 0, 6'd63);
        send_item(bsl_pkg::FUNC_RANK, 0, 0, 0);
        send_item(bsl_pkg::FUNC_UPDATE, 0, 64'd5, 0);
        send_item(bsl_pkg::FUNC_RANK, 0, 0, 0);
        send_item(bsl_pkg::FUNC_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_item(bsl_pkg::FUNC_UPDATE, 7, 64'd5, 0);
        send_item(bsl_pkg::FUNC_UPDATE, 8, 64'd5, 0);
        send_item(bsl_pkg::FUNC_UPDATE, 7, 64'd5, 0);
        send_item(bsl_pkg::FUNC_UPDATE, 7, 64'd6, 0);
        send_item(bsl_pkg::FUNC_UPDATE, 8, 64'd3, 0);
        send_item(bsl_pkg::FUNC_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 0);
        send_item(bsl_pkg::FUNC_UPDATE, 9, 64'd4, 0);
        send_item(bsl_pkg::FUNC_RANK, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
        send_item(bsl_pkg::FUNC_READ, 0, 0, 6'd0);
        send_item(bsl_pkg::FUNC_READ, 0, 0, 6'd4);
        send_item(bsl_pkg::FUNC_READ, 0, 0, 6'd5);
        send_item(bsl_pkg::FUNC_CLEAR, 0, 0, 0);
        send_item(bsl_pkg::FUNC_READ, 0, 0, 6'd0);

        // tiny limit: rejects and evictions
        write_limit(7'd2);
        send_item(bsl_pkg::FUNC_UPDATE, 1, 64'd10, 0);
        send_item(bsl_pkg::FUNC_UPDATE, 2, 64'd20, 0);
        send_item(bsl_pkg::FUNC_UPDATE, 3, 64'd10, 0);
        send_item(bsl_pkg::FUNC_UPDATE, 3, 64'd11, 0);
        random_phase(60);

        // full capacity, fill up, then lower the limit below count
        write_limit(7'd64);
        send_idle_pct = 12;
        recv_idle_pct = 76;
        fill_board(66);
        random_phase(60);
        write_limit(7'd10);
        random_phase(50);

        // long receiver hold-off while the sender keeps pushing
        write_limit(7'd0);
        send_idle_pct = 76;
        recv_idle_pct = 12;
        hold_off_cycles = 200;
        send_idle_pct = 0;
        random_phase(20);
        send_idle_pct = 76;
        random_phase(100);

        write_limit(7'd127);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(60);
        write_limit(7'd1);
        random_phase(40);
        write_limit(7'd33);
        random_phase(40);

        wait_idle();
        repeat (20) @(negedge aclk);
        $display("ran %0d items (%0d clears), checked %0d results, limits 0..127",
                 item_total, clear_total, board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb_bounded_sorted_leaderboard: PASS");
        end else begin
            $display("tb_bounded_sorted_leaderboard: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/bsl_pkg.sv
hdl/bsl_cell.sv
hdl/bounded_sorted_leaderboard.sv
hdl/bsl_checker.sv
dv/tb_bounded_sorted_leaderboard.sv
